>>> hw/rtl/hidrp_pkg.sv
package hidrp_pkg;

  // Depth of the push/pop stack of global items
  localparam int STACK_ENTRIES = 4;
  localparam int STK_IDX_W = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int DEPTH_W = $clog2(STACK_ENTRIES + 1);

  localparam int IN_W = 8;
  localparam int OUT_W = 80;
  localparam int LAYOUT_W = 73;

  localparam logic [7:0] LONG_ITEM_HDR = 8'hFE;
  localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
  localparam logic [15:0] PAGE_BUTTON = 16'h0009;
  localparam logic [15:0] USAGE_HAT = 16'h0039;

  // Item types
  localparam logic [1:0] TYPE_MAIN = 2'd0;
  localparam logic [1:0] TYPE_GLOBAL = 2'd1;
  localparam logic [1:0] TYPE_LOCAL = 2'd2;

  // Main tags
  localparam logic [3:0] TAG_INPUT = 4'h8;
  localparam logic [3:0] TAG_COLLECTION = 4'hA;

  // Global tags
  localparam logic [3:0] TAG_USAGE_PAGE = 4'h0;
  localparam logic [3:0] TAG_REPORT_SIZE = 4'h7;
  localparam logic [3:0] TAG_REPORT_ID = 4'h8;
  localparam logic [3:0] TAG_REPORT_COUNT = 4'h9;
  localparam logic [3:0] TAG_PUSH = 4'hA;
  localparam logic [3:0] TAG_POP = 4'hB;

  // Local tags
  localparam logic [3:0] TAG_USAGE = 4'h0;

  // Result fields, first member in the highest bits so layout_valid sits at bit 0
  typedef struct packed {
    logic [13:0] report_length;
    logic [7:0]  hat_width;
    logic [15:0] hat_bit_offset;
    logic        has_hat;
    logic [7:0]  button_count;
    logic [15:0] button_bit_offset;
    logic [7:0]  report_id;
    logic        has_report_id;
    logic        layout_valid;
  } layout_t;

  // Short item data size; size code 3 means 4 bytes
  function automatic logic [2:0] data_size(input logic [7:0] hdr);
    logic [2:0] s;
    s = (hdr[1:0] == 2'd3) ? 3'd4 : {1'b0, hdr[1:0]};
    return s;
  endfunction

endpackage

>>> hw/rtl/hid_report_descriptor_parser_core.sv
// HID report descriptor parser. Feed the descriptor one byte per transfer on the
// s_ side, with s_tlast on its final byte; one result transfer follows on the m_
// side and the parser is then back in its reset state, ready for the next
// descriptor. One byte is taken every cycle while the input is not stalled; a byte
// passes an input register and the item decode logic, which updates the parse state
// in the same cycle. m_tvalid rises as the last byte leaves the input register and
// its result is loaded into the output register. The loop that sets this rate is the
// per-byte state update (16x16 size-by-count product and offset add). Input stalls
// only while a result waits in the output register and another last byte is ready
// to produce the next one.
module hid_report_descriptor_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hidrp_pkg::IN_W-1:0]    s_tdata,   // [7:0] map_byte
  input  logic                          s_tlast,   // last_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] layout_valid, [1] has_report_id, [9:2] report_id,
  // [25:10] button_bit_offset, [33:26] button_count, [34] has_hat,
  // [50:35] hat_bit_offset, [58:51] hat_width, [72:59] report_length, rest zero
  output logic [hidrp_pkg::OUT_W-1:0]   m_tdata
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               in_last;
  logic               advance;
  hidrp_pkg::layout_t layout;

  // A last byte moves on only when the output register is free or draining
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hidrp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .last    (in_last),
    .layout  (layout)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      m_tdata <= {(hidrp_pkg::OUT_W - hidrp_pkg::LAYOUT_W)'(0), layout};
    end
  end

endmodule

>>> hw/rtl/hidrp_engine.sv
module hidrp_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  input  logic                last,
  output hidrp_pkg::layout_t  layout
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_LONGLEN,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic [15:0] usage_page;
    logic [15:0] field_size;
    logic [15:0] field_count;
  } stack_entry_t;

  phase_t      phase, phase_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [7:0]  item_header, item_header_next;
  logic [15:0] value_accum, value_accum_next;
  logic [15:0] usage_page, usage_page_next;
  logic [15:0] field_size, field_size_next;
  logic [15:0] field_count, field_count_next;
  logic [15:0] local_usage, local_usage_next;
  logic [15:0] current_id, current_id_next;
  logic        id_seen, id_seen_next;
  logic [15:0] bit_position, bit_position_next;
  logic [hidrp_pkg::DEPTH_W-1:0] stack_depth, stack_depth_next;
  stack_entry_t global_stack [hidrp_pkg::STACK_ENTRIES];

  logic        cap_valid, cap_valid_next;
  logic        cap_has_id, cap_has_id_next;
  logic [7:0]  cap_id, cap_id_next;
  logic [15:0] cap_btn_off, cap_btn_off_next;
  logic [7:0]  cap_btn_cnt, cap_btn_cnt_next;
  logic        cap_has_hat, cap_has_hat_next;
  logic [15:0] cap_hat_off, cap_hat_off_next;
  logic [7:0]  cap_hat_w, cap_hat_w_next;

  logic        run;
  logic [7:0]  run_hdr;
  logic [15:0] run_val;
  logic [1:0]  run_type;
  logic [3:0]  run_tag;
  logic [2:0]  hdr_size;
  logic [2:0]  hdr_size_in;
  logic [2:0]  data_idx;
  logic [15:0] accum_new;
  logic [31:0] field_bits;
  logic        push_en;
  logic [hidrp_pkg::DEPTH_W-1:0]   depth_dec;
  logic [hidrp_pkg::STK_IDX_W-1:0] push_idx;
  logic [hidrp_pkg::STK_IDX_W-1:0] pop_idx;
  stack_entry_t pop_entry;
  logic [16:0] len_round;

  assign hdr_size    = hidrp_pkg::data_size(item_header);
  assign hdr_size_in = hidrp_pkg::data_size(byte_in);
  assign data_idx    = hdr_size - bytes_left[2:0];
  assign field_bits  = field_count * field_size;
  assign depth_dec   = stack_depth - hidrp_pkg::DEPTH_W'(1);
  assign push_idx    = stack_depth[hidrp_pkg::STK_IDX_W-1:0];
  assign pop_idx     = depth_dec[hidrp_pkg::STK_IDX_W-1:0];
  assign pop_entry   = global_stack[pop_idx];
  assign run_type    = run_hdr[3:2];
  assign run_tag     = run_hdr[7:4];

  // Byte framing: header, data bytes, long item length and skip
  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    item_header_next = item_header;
    value_accum_next = value_accum;
    run              = 1'b0;
    run_hdr          = item_header;
    run_val          = 16'h0000;
    accum_new        = value_accum;
    case (phase)
      PH_HEADER: begin
        if (byte_in == hidrp_pkg::LONG_ITEM_HDR) begin
          phase_next = PH_LONGLEN;
        end else begin
          item_header_next = byte_in;
          value_accum_next = 16'h0000;
          bytes_left_next  = {6'd0, hdr_size_in};
          if (hdr_size_in == 3'd0) begin
            run     = 1'b1;
            run_hdr = byte_in;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        if (data_idx == 3'd0) begin
          accum_new = {8'h00, byte_in};
        end else if (data_idx == 3'd1) begin
          accum_new = {byte_in, value_accum[7:0]};
        end
        value_accum_next = accum_new;
        bytes_left_next  = bytes_left - 9'd1;
        if (bytes_left == 9'd1) begin
          // one-byte values are sign extended
          if (hdr_size == 3'd1) begin
            value_accum_next = {{8{byte_in[7]}}, byte_in};
          end
          phase_next = PH_HEADER;
          run        = 1'b1;
          run_val    = value_accum_next;
        end
      end
      PH_LONGLEN: begin
        bytes_left_next = {1'b0, byte_in} + 9'd1;
        phase_next      = PH_SKIP;
      end
      default: begin
        if (bytes_left != 9'd0) begin
          bytes_left_next = bytes_left - 9'd1;
        end
        if (bytes_left <= 9'd1) begin
          phase_next = PH_HEADER;
        end
      end
    endcase
  end

  // Item execution
  always_comb begin
    usage_page_next   = usage_page;
    field_size_next   = field_size;
    field_count_next  = field_count;
    local_usage_next  = local_usage;
    current_id_next   = current_id;
    id_seen_next      = id_seen;
    bit_position_next = bit_position;
    stack_depth_next  = stack_depth;
    push_en           = 1'b0;
    cap_valid_next    = cap_valid;
    cap_has_id_next   = cap_has_id;
    cap_id_next       = cap_id;
    cap_btn_off_next  = cap_btn_off;
    cap_btn_cnt_next  = cap_btn_cnt;
    cap_has_hat_next  = cap_has_hat;
    cap_hat_off_next  = cap_hat_off;
    cap_hat_w_next    = cap_hat_w;
    if (run) begin
      if (run_type == hidrp_pkg::TYPE_GLOBAL) begin
        case (run_tag)
          hidrp_pkg::TAG_USAGE_PAGE:   usage_page_next = run_val;
          hidrp_pkg::TAG_REPORT_SIZE:  field_size_next = run_val;
          hidrp_pkg::TAG_REPORT_COUNT: field_count_next = run_val;
          hidrp_pkg::TAG_REPORT_ID: begin
            // offsets restart on the first ID and on every change of ID
            if (!id_seen || run_val != current_id) begin
              bit_position_next = 16'h0000;
            end
            id_seen_next    = 1'b1;
            current_id_next = run_val;
          end
          hidrp_pkg::TAG_PUSH: begin
            if (stack_depth < hidrp_pkg::DEPTH_W'(hidrp_pkg::STACK_ENTRIES)) begin
              push_en          = 1'b1;
              stack_depth_next = stack_depth + hidrp_pkg::DEPTH_W'(1);
            end
          end
          hidrp_pkg::TAG_POP: begin
            if (stack_depth != '0) begin
              stack_depth_next = depth_dec;
              usage_page_next  = pop_entry.usage_page;
              field_size_next  = pop_entry.field_size;
              field_count_next = pop_entry.field_count;
            end
          end
          default: ;
        endcase
      end else if (run_type == hidrp_pkg::TYPE_LOCAL) begin
        if (run_tag == hidrp_pkg::TAG_USAGE) begin
          local_usage_next = run_val;
        end
      end else if (run_type == hidrp_pkg::TYPE_MAIN) begin
        if (run_tag == hidrp_pkg::TAG_COLLECTION) begin
          local_usage_next = 16'h0000;
        end else if (run_tag == hidrp_pkg::TAG_INPUT) begin
          if (usage_page == hidrp_pkg::PAGE_BUTTON && field_size == 16'd1 && !cap_valid) begin
            cap_valid_next   = 1'b1;
            cap_has_id_next  = id_seen;
            cap_id_next      = current_id[7:0];
            cap_btn_off_next = bit_position;
            cap_btn_cnt_next = field_count[7:0];
          end else if (usage_page == hidrp_pkg::PAGE_DESKTOP &&
                       local_usage == hidrp_pkg::USAGE_HAT && !cap_has_hat) begin
            cap_has_hat_next = 1'b1;
            cap_hat_off_next = bit_position;
            cap_hat_w_next   = field_size[7:0];
          end
          bit_position_next = bit_position + field_bits[15:0];
          local_usage_next  = 16'h0000;
        end
      end
    end
  end

  // Result as seen after this byte; zeroed fields where nothing was found
  assign len_round = {1'b0, bit_position_next} + 17'd7;

  always_comb begin
    layout.layout_valid      = cap_valid_next;
    layout.has_report_id     = cap_valid_next & cap_has_id_next;
    layout.report_id         = cap_valid_next ? cap_id_next : 8'h00;
    layout.button_bit_offset = cap_valid_next ? cap_btn_off_next : 16'h0000;
    layout.button_count      = cap_valid_next ? cap_btn_cnt_next : 8'h00;
    layout.has_hat           = cap_has_hat_next;
    layout.hat_bit_offset    = cap_has_hat_next ? cap_hat_off_next : 16'h0000;
    layout.hat_width         = cap_has_hat_next ? cap_hat_w_next : 8'h00;
    layout.report_length     = cap_valid_next ?
                               (len_round[16:3] + {13'd0, id_seen_next}) : 14'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase        <= PH_HEADER;
      bytes_left   <= 9'd0;
      item_header  <= 8'h00;
      value_accum  <= 16'h0000;
      usage_page   <= 16'h0000;
      field_size   <= 16'h0000;
      field_count  <= 16'h0000;
      local_usage  <= 16'h0000;
      current_id   <= 16'h0000;
      id_seen      <= 1'b0;
      bit_position <= 16'h0000;
      stack_depth  <= '0;
      cap_valid    <= 1'b0;
      cap_has_id   <= 1'b0;
      cap_id       <= 8'h00;
      cap_btn_off  <= 16'h0000;
      cap_btn_cnt  <= 8'h00;
      cap_has_hat  <= 1'b0;
      cap_hat_off  <= 16'h0000;
      cap_hat_w    <= 8'h00;
    end else if (step) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      item_header  <= item_header_next;
      value_accum  <= value_accum_next;
      usage_page   <= usage_page_next;
      field_size   <= field_size_next;
      field_count  <= field_count_next;
      local_usage  <= local_usage_next;
      current_id   <= current_id_next;
      id_seen      <= id_seen_next;
      bit_position <= bit_position_next;
      stack_depth  <= stack_depth_next;
      cap_valid    <= cap_valid_next;
      cap_has_id   <= cap_has_id_next;
      cap_id       <= cap_id_next;
      cap_btn_off  <= cap_btn_off_next;
      cap_btn_cnt  <= cap_btn_cnt_next;
      cap_has_hat  <= cap_has_hat_next;
      cap_hat_off  <= cap_hat_off_next;
      cap_hat_w    <= cap_hat_w_next;
    end
  end

  // Stack entries are only read below the depth pointer, so they need no reset
  always_ff @(posedge clk) begin
    if (step && push_en) begin
      global_stack[push_idx] <= '{usage_page, field_size, field_count};
    end
  end

endmodule

>>> verif/hid_report_descriptor_parser_core_tb.sv
`timescale 1ns / 100ps

module hid_report_descriptor_parser_core_tb;

  // Main tags and item type that the block ignores
  localparam logic [3:0] TAG_OUTPUT = 4'h9;
  localparam logic [3:0] TAG_FEATURE = 4'hB;
  localparam logic [3:0] TAG_END_COLLECTION = 4'hC;
  localparam logic [1:0] TYPE_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    PARSE_HEADER,
    PARSE_DATA,
    PARSE_LONG_SIZE,
    PARSE_LONG_BODY
  } parse_phase_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [hidrp_pkg::IN_W-1:0]    s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [hidrp_pkg::OUT_W-1:0]   m_tdata;

  always #5 clk = ~clk;

  hid_report_descriptor_parser_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Descriptor parse state as the block should hold it
  parse_phase_t       phase;
  int unsigned        skip_left;
  logic [7:0]         pend_hdr;
  logic [15:0]        pend_value;
  logic [15:0]        cur_page, cur_size, cur_count, cur_usage, cur_id;
  logic               id_given;
  logic [15:0]        bit_pos;
  logic [15:0]        saved_page [hidrp_pkg::STACK_ENTRIES];
  logic [15:0]        saved_size [hidrp_pkg::STACK_ENTRIES];
  logic [15:0]        saved_count [hidrp_pkg::STACK_ENTRIES];
  int unsigned        depth;
  hidrp_pkg::layout_t found;
  hidrp_pkg::layout_t expected_layouts[$];

  logic [7:0]   desc_buf[$];
  int           mismatches = 0;
  int           bytes_sent = 0;
  int           burst_left = 0;
  int           gap_max = 3;
  bit           rx_stalls = 1'b1;
  bit           hold_req = 1'b0;
  int           hold_len = 0;

  function automatic int unsigned item_bytes(input logic [7:0] hdr);
    case (hdr[1:0])
      2'd3: return 4;
      default: return hdr[1:0];
    endcase
  endfunction

  task automatic append_byte(input logic [7:0] b);
    desc_buf = {desc_buf, b};
  endtask

  task automatic clear_parser();
    phase = PARSE_HEADER;
    skip_left = 0;
    pend_hdr = '0;
    pend_value = '0;
    cur_page = '0;
    cur_size = '0;
    cur_count = '0;
    cur_usage = '0;
    cur_id = '0;
    id_given = 1'b0;
    bit_pos = '0;
    depth = 0;
    found = '0;
    for (int i = 0; i < hidrp_pkg::STACK_ENTRIES; i++) begin
      saved_page[i] = '0;
      saved_size[i] = '0;
      saved_count[i] = '0;
    end
  endtask

  task automatic apply_item(input logic [7:0] hdr, input logic [15:0] val);
    logic [1:0]  ity;
    logic [3:0]  itag;
    logic [31:0] span;
    ity = hdr[3:2];
    itag = hdr[7:4];
    case (ity)
      hidrp_pkg::TYPE_GLOBAL: begin
        case (itag)
          hidrp_pkg::TAG_USAGE_PAGE: cur_page = val;
          hidrp_pkg::TAG_REPORT_SIZE: cur_size = val;
          hidrp_pkg::TAG_REPORT_ID: begin
            // first ID, or a change of ID, starts a new report
            if (!id_given || val != cur_id) bit_pos = '0;
            id_given = 1'b1;
            cur_id = val;
          end
          hidrp_pkg::TAG_REPORT_COUNT: cur_count = val;
          hidrp_pkg::TAG_PUSH: begin
            if (depth < hidrp_pkg::STACK_ENTRIES) begin
              saved_page[depth] = cur_page;
              saved_size[depth] = cur_size;
              saved_count[depth] = cur_count;
              depth++;
            end
          end
          hidrp_pkg::TAG_POP: begin
            if (depth > 0) begin
              depth--;
              cur_page = saved_page[depth];
              cur_size = saved_size[depth];
              cur_count = saved_count[depth];
            end
          end
          default: ;
        endcase
      end
      hidrp_pkg::TYPE_LOCAL: begin
        if (itag == hidrp_pkg::TAG_USAGE) cur_usage = val;
      end
      hidrp_pkg::TYPE_MAIN: begin
        if (itag == hidrp_pkg::TAG_COLLECTION) begin
          cur_usage = '0;
        end else if (itag == hidrp_pkg::TAG_INPUT) begin
          if (cur_page == hidrp_pkg::PAGE_BUTTON && cur_size == 16'd1 &&
              !found.layout_valid) begin
            found.layout_valid = 1'b1;
            found.has_report_id = id_given;
            found.report_id = cur_id[7:0];
            found.button_bit_offset = bit_pos;
            found.button_count = cur_count[7:0];
          end else if (cur_page == hidrp_pkg::PAGE_DESKTOP &&
                       cur_usage == hidrp_pkg::USAGE_HAT && !found.has_hat) begin
            found.has_hat = 1'b1;
            found.hat_bit_offset = bit_pos;
            found.hat_width = cur_size[7:0];
          end
          span = 32'(cur_count) * 32'(cur_size);
          bit_pos = bit_pos + span[15:0];
          cur_usage = '0;
        end
      end
      default: ;
    endcase
  endtask

  // Advance the parse state by one accepted byte; the last byte yields the layout
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned        len;
    int unsigned        k;
    hidrp_pkg::layout_t res;
    case (phase)
      PARSE_HEADER: begin
        if (b == hidrp_pkg::LONG_ITEM_HDR) begin
          phase = PARSE_LONG_SIZE;
        end else begin
          pend_hdr = b;
          pend_value = '0;
          skip_left = item_bytes(b);
          if (skip_left == 0) apply_item(b, 16'h0000);
          else phase = PARSE_DATA;
        end
      end
      PARSE_DATA: begin
        len = item_bytes(pend_hdr);
        k = len - skip_left;
        if (k == 0) pend_value = {8'h00, b};
        else if (k == 1) pend_value[15:8] = b;
        skip_left--;
        if (skip_left == 0) begin
          if (len == 1 && pend_value[7]) pend_value[15:8] = 8'hFF;
          phase = PARSE_HEADER;
          apply_item(pend_hdr, pend_value);
        end
      end
      PARSE_LONG_SIZE: begin
        // tag byte plus the data bytes
        skip_left = int'(b) + 1;
        phase = PARSE_LONG_BODY;
      end
      default: begin
        if (skip_left > 0) skip_left--;
        if (skip_left == 0) phase = PARSE_HEADER;
      end
    endcase
    if (last) begin
      res = found;
      if (found.layout_valid)
        res.report_length = 14'((int'(bit_pos) + 7) / 8 + (id_given ? 1 : 0));
      expected_layouts = {expected_layouts, res};
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) report_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin
    hidrp_pkg::layout_t got;
    hidrp_pkg::layout_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = hidrp_pkg::layout_t'(m_tdata[hidrp_pkg::LAYOUT_W-1:0]);
      if (expected_layouts.size() == 0) begin
        report_mismatch("result with nothing pending, layout_valid", 16'h0, got.layout_valid);
      end else begin
        want = expected_layouts.pop_front();
        compare_field("layout_valid", want.layout_valid, got.layout_valid);
        compare_field("has_report_id", want.has_report_id, got.has_report_id);
        compare_field("report_id", want.report_id, got.report_id);
        compare_field("button_bit_offset", want.button_bit_offset, got.button_bit_offset);
        compare_field("button_count", want.button_count, got.button_count);
        compare_field("has_hat", want.has_hat, got.has_hat);
        compare_field("hat_bit_offset", want.hat_bit_offset, got.hat_bit_offset);
        compare_field("hat_width", want.hat_width, got.hat_width);
        compare_field("report_length", want.report_length, got.report_length);
      end
    end
  end

  // Receiver: rotating stall pattern, long hold-off on request
  initial begin
    int          hold_cnt;
    int          rot_cnt;
    logic [12:0] ready_pattern;
    hold_cnt = 0;
    rot_cnt = 0;
    ready_pattern = '1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_cnt = hold_len;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (!rx_stalls) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[12:1]};
        rot_cnt++;
        if (rot_cnt == 13) begin
          rot_cnt = 0;
          ready_pattern = 13'($urandom) | 13'd1;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    absorb_byte(b, last);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_descriptor();
    for (int i = 0; i < desc_buf.size(); i++)
      send_byte(desc_buf[i], i == desc_buf.size() - 1);
    desc_buf.delete();
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_layouts.size() != 0) @(posedge clk);
  endtask

  task automatic put_item(input logic [1:0] ity, input logic [3:0] itag,
                          input int nbytes, input logic [31:0] val);
    logic [1:0] code;
    code = (nbytes == 4) ? 2'd3 : 2'(nbytes);
    append_byte({itag, ity, code});
    for (int i = 0; i < nbytes; i++) append_byte(val[8*i +: 8]);
  endtask

  function automatic int pick_len();
    case ($urandom_range(0, 9))
      0: return 0;
      7, 8: return 2;
      9: return 4;
      default: return 1;
    endcase
  endfunction

  task automatic put_random_item();
    int          pick;
    int          n;
    int          sel;
    int          len;
    logic [31:0] v;
    pick = $urandom_range(0, 99);
    n = pick_len();
    sel = $urandom_range(0, 3);
    v = $urandom;
    if (pick < 10) begin
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, n,
               (sel == 0) ? 32'(hidrp_pkg::PAGE_DESKTOP) :
               (sel == 1) ? 32'(hidrp_pkg::PAGE_BUTTON) : v);
    end else if (pick < 20) begin
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_SIZE, n,
               (sel < 2) ? 32'd1 : (sel == 2) ? 32'($urandom_range(2, 8)) : v);
    end else if (pick < 30) begin
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_COUNT, n,
               (sel < 3) ? 32'($urandom_range(1, 16)) : v);
    end else if (pick < 36) begin
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_ID, n,
               (sel < 3) ? 32'($urandom_range(0, 3)) : v);
    end else if (pick < 46) begin
      put_item(hidrp_pkg::TYPE_LOCAL, hidrp_pkg::TAG_USAGE, n,
               (sel < 2) ? 32'(hidrp_pkg::USAGE_HAT) : v);
    end else if (pick < 60) begin
      put_item(hidrp_pkg::TYPE_MAIN, hidrp_pkg::TAG_INPUT, n, v);
    end else if (pick < 66) begin
      put_item(hidrp_pkg::TYPE_MAIN, (sel == 0) ? TAG_OUTPUT : (sel == 1) ? TAG_FEATURE :
               (sel == 2) ? hidrp_pkg::TAG_COLLECTION : TAG_END_COLLECTION, n, v);
    end else if (pick < 72) begin
      put_item(hidrp_pkg::TYPE_GLOBAL, sel[0] ? hidrp_pkg::TAG_PUSH : hidrp_pkg::TAG_POP,
               n, v);
    end else if (pick < 75) begin
      // fill the stack past its depth, then unwind a random amount
      repeat (5) put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_PUSH, 0, 0);
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, 1, v);
      repeat ($urandom_range(0, 6)) put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_POP, 0, 0);
    end else if (pick < 80) begin
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      append_byte(hidrp_pkg::LONG_ITEM_HDR);
      append_byte(8'(len));
      append_byte(8'($urandom));
      repeat (len) append_byte(8'($urandom));
    end else if (pick < 90) begin
      put_item(2'($urandom), 4'($urandom), n, v);
    end else begin
      repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
    end
  endtask

  task automatic put_gamepad_items();
    if ($urandom_range(0, 1))
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_ID, 1, $urandom_range(0, 3));
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, $urandom_range(1, 2),
             hidrp_pkg::PAGE_BUTTON);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_SIZE, 1, 1);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_COUNT, 1, $urandom_range(1, 32));
    put_item(hidrp_pkg::TYPE_MAIN, hidrp_pkg::TAG_INPUT, 1, $urandom);
    if ($urandom_range(0, 1)) put_random_item();
    if ($urandom_range(0, 3) != 0) begin
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, 1, hidrp_pkg::PAGE_DESKTOP);
      put_item(hidrp_pkg::TYPE_LOCAL, hidrp_pkg::TAG_USAGE, 1, hidrp_pkg::USAGE_HAT);
      put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_SIZE, 1, $urandom_range(1, 8));
      put_item(hidrp_pkg::TYPE_MAIN, hidrp_pkg::TAG_INPUT, 1, $urandom);
    end
  endtask

  // Leave the final item unfinished
  task automatic put_cut_item();
    int len;
    if ($urandom_range(0, 1)) begin
      put_item(2'($urandom), 4'($urandom), 4, $urandom);
      repeat ($urandom_range(1, 4)) void'(desc_buf.pop_back());
    end else begin
      append_byte(hidrp_pkg::LONG_ITEM_HDR);
      if ($urandom_range(0, 1)) begin
        len = $urandom_range(0, 3);
        append_byte(8'(len));
        repeat ($urandom_range(0, len)) append_byte(8'($urandom));
      end
    end
  endtask

  task automatic build_random_descriptor();
    desc_buf.delete();
    repeat ($urandom_range(0, 3)) put_random_item();
    if ($urandom_range(0, 1)) put_gamepad_items();
    repeat ($urandom_range(0, 4)) put_random_item();
    if (desc_buf.size() == 0 || $urandom_range(0, 7) == 0) put_cut_item();
  endtask

  task automatic test_gamepad_layout();
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, 1, hidrp_pkg::PAGE_BUTTON);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_ID, 1, 32'h83); // sign-extends
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_SIZE, 1, 1);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_COUNT, 1, 12);
    put_item(hidrp_pkg::TYPE_MAIN, hidrp_pkg::TAG_INPUT, 1, 2);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, 1, hidrp_pkg::PAGE_DESKTOP);
    put_item(hidrp_pkg::TYPE_LOCAL, hidrp_pkg::TAG_USAGE, 1, hidrp_pkg::USAGE_HAT);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_SIZE, 4, 32'hFFFF_0004);
    put_item(hidrp_pkg::TYPE_MAIN, hidrp_pkg::TAG_INPUT, 0, 0);
    send_descriptor();
  endtask

  task automatic test_long_item_and_cutoff();
    append_byte(hidrp_pkg::LONG_ITEM_HDR);
    append_byte(8'h00);
    append_byte(8'hFF);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_COUNT, 2, 16'h1234);
    void'(desc_buf.pop_back());
    send_descriptor();
  endtask

  // Hat with no buttons, stack limits, ignored items, offset wrap
  task automatic test_stack_and_hat_only();
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_POP, 0, 0);
    repeat (5) put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_PUSH, 0, 0);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_USAGE_PAGE, 1, hidrp_pkg::PAGE_DESKTOP);
    put_item(hidrp_pkg::TYPE_LOCAL, hidrp_pkg::TAG_USAGE, 1, hidrp_pkg::USAGE_HAT);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_SIZE, 2, 16'hFFFF);
    put_item(hidrp_pkg::TYPE_GLOBAL, hidrp_pkg::TAG_REPORT_COUNT, 2, 16'hFFFF);
    put_item(hidrp_pkg::TYPE_MAIN, TAG_OUTPUT, 0, 0);
    put_item(hidrp_pkg::TYPE_MAIN, hidrp_pkg::TAG_INPUT, 0, 0);
    put_item(TYPE_RESERVED, 4'hF, 0, 0);
    send_descriptor();
  endtask

  task automatic test_random_descriptors(input int byte_goal, input int min_desc,
                                         input int gaps, input bit stalls);
    int start;
    int count;
    gap_max = gaps;
    rx_stalls = stalls;
    start = bytes_sent;
    count = 0;
    while (bytes_sent - start < byte_goal || count < min_desc) begin
      build_random_descriptor();
      send_descriptor();
      count++;
    end
  endtask

  // Receiver holds off while the sender keeps offering, so input stalls
  task automatic test_output_backpressure();
    gap_max = 0;
    hold_len = 300;
    hold_req = 1'b1;
    repeat (14) begin
      if ($urandom_range(0, 1)) build_random_descriptor();
      else append_byte(8'($urandom));
      send_descriptor();
    end
  endtask

  task automatic test_drain_pause();
    gap_max = 2;
    rx_stalls = 1'b1;
    repeat (3) begin
      build_random_descriptor();
      send_descriptor();
      wait_results_drained();
    end
  endtask

  initial begin
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_gamepad_layout();
    test_long_item_and_cutoff();
    test_stack_and_hat_only();
    test_random_descriptors(180, 12, 4, 1'b1);
    test_output_backpressure();
    test_random_descriptors(120, 10, 0, 1'b0);
    test_drain_pause();
    test_random_descriptors(180, 12, 8, 1'b1);
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("hid_report_descriptor_parser_core: match");
    end else begin
      $display("hid_report_descriptor_parser_core: mismatch");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("hid_report_descriptor_parser_core: mismatch");
    $finish;
  end

endmodule
